// File: src/assert_macros.svh
// assertion macros shared by the receiver modules
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// assert that a implies b at each clock edge, outside reset
`define ASSERT_IMPL(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
// assert that a implies b at the next edge, outside reset
`define ASSERT_NEXT(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`endif

// File: src/ymcrc_pkg.sv
// shared types and constants of the ymodem crc receiver
// no dependencies
package ymcrc_pkg;
  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_BYTE = 2'd1;
  localparam logic [1:0] REQ_TIMEOUT = 2'd2;
  localparam logic [1:0] REQ_NONE = 2'd3;
  localparam logic [1:0] CFG_BASE = 2'd0;
  localparam logic [1:0] CFG_SIZE = 2'd1;
  localparam logic [1:0] CFG_RETRY = 2'd2;
  localparam logic [7:0] CH_SOH = 8'h01;
  localparam logic [7:0] CH_STX = 8'h02;
  localparam logic [7:0] CH_EOT = 8'h04;
  localparam logic [7:0] CH_ACK = 8'h06;
  localparam logic [7:0] CH_NAK = 8'h15;
  localparam logic [7:0] CH_CAN = 8'h18;
  localparam logic [7:0] CH_REQ = 8'h43;
  localparam logic [1:0] ST_RUN = 2'd0;
  localparam logic [1:0] ST_DONE = 2'd1;
  localparam logic [1:0] ST_TIMEOUT = 2'd2;
  localparam logic [1:0] ST_CANCEL = 2'd3;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        wr_valid;
    logic [31:0] wr_addr;
    logic [7:0]  wr_data;
    logic        done_res;
    logic [1:0]  status;
    logic [20:0] saved_bytes;
    logic        last;
  } result_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
    end
    return c;
  endfunction
endpackage

// File: src/ymodem_crc_block_receiver.sv
// channel | dir | tdata (low bit up)                            | tuser (low bit up)
// s_axis  | in  | rx_byte[7:0]                                  | req_type[1:0]
// m_axis  | out | tx_byte[7:0], wr_addr[39:8], wr_data[47:40],  | tx_valid, wr_valid,
//         |     | status[49:48], saved_bytes[70:50], pad to 72  | done_res; tlast = last
// cfg     | in  | cfg_we, cfg_index, cfg_data                   | -
// one event per cycle while tready is high; the protocol engine updates state in the beat it accepts
// results sit in a four-entry queue; an event is accepted while two slots are free
// a result can leave the cycle after its event; the result side drains one per cycle while m_axis_tready is high
// rst is synchronous and clears control
// top level; depends on ymcrc_pkg, ymcrc_engine, ymcrc_queue
module ymodem_crc_block_receiver
  import ymcrc_pkg::*;
#(
  parameter int LONG_BLOCK_BYTES = 1024,
  parameter int SHORT_BLOCK_BYTES = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // rx_byte
  input  logic [1:0]  s_axis_tuser,  // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,  // tx_byte, wr_addr, wr_data, status, saved_bytes
  output logic [2:0]  m_axis_tuser,  // tx_valid, wr_valid, done_res
  output logic        m_axis_tlast
);
  logic       in_go;
  logic [1:0] res_count;
  result_t    res0, res1, q_out;
  logic       room2;

  assign s_axis_tready = room2;
  assign in_go = s_axis_tvalid && s_axis_tready;

  ymcrc_engine #(
    .LONG_BLOCK_BYTES(LONG_BLOCK_BYTES),
    .SHORT_BLOCK_BYTES(SHORT_BLOCK_BYTES)
  ) u_engine (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_go(in_go), .req_type(s_axis_tuser), .rx_byte(s_axis_tdata),
    .res_count(res_count), .res0(res0), .res1(res1)
  );

  ymcrc_queue u_queue (
    .clk(clk), .rst(rst), .push(in_go), .push_count(res_count),
    .push0(res0), .push1(res1), .room2(room2),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(q_out)
  );

  assign m_axis_tdata = {1'b0, q_out.saved_bytes, q_out.status, q_out.wr_data,
                         q_out.wr_addr, q_out.tx_byte};
  assign m_axis_tuser = {q_out.done_res, q_out.wr_valid, q_out.tx_valid};
  assign m_axis_tlast = q_out.last;
endmodule

// File: src/ymcrc_engine.sv
// front part: protocol state and per-event classification into results
// depends on ymcrc_pkg and assert_macros.svh
module ymcrc_engine
  import ymcrc_pkg::*;
#(
  parameter int LONG_BLOCK_BYTES = 1024,
  parameter int SHORT_BLOCK_BYTES = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_go,
  input  logic [1:0]  req_type,
  input  logic [7:0]  rx_byte,
  output logic [1:0]  res_count,
  output result_t     res0,
  output result_t     res1
);
  localparam logic [10:0] LONG_END = 11'(LONG_BLOCK_BYTES + 2);
  localparam logic [10:0] SHORT_END = 11'(SHORT_BLOCK_BYTES + 2);
  localparam logic [20:0] LONG_LEN = 21'(LONG_BLOCK_BYTES);
  localparam logic [20:0] SHORT_LEN = 21'(SHORT_BLOCK_BYTES);

  typedef enum logic [1:0] {PH_DONE, PH_WAIT, PH_PACKET} phase_t;

  logic [31:0] base_addr;
  logic [20:0] size_limit;
  logic [3:0]  retry_limit;
  phase_t      phase, phase_next;
  logic [10:0] byte_index, byte_index_next;
  logic        long_packet, long_packet_next;
  logic [7:0]  block_number, block_number_next;
  logic        header_ok, header_ok_next;
  logic [15:0] running_crc, running_crc_next;
  logic [7:0]  received_crc, received_crc_next;
  logic [7:0]  expected_block, expected_block_next;
  logic [20:0] committed_offset, committed_offset_next;
  logic [3:0]  timeout_count, timeout_count_next;

  logic [10:0] pkt_end;
  logic [20:0] pkt_len, pos, room;
  logic [15:0] rx_crc;

  always_comb begin
    result_t r0, r1;
    phase_next = phase;
    byte_index_next = byte_index;
    long_packet_next = long_packet;
    block_number_next = block_number;
    header_ok_next = header_ok;
    running_crc_next = running_crc;
    received_crc_next = received_crc;
    expected_block_next = expected_block;
    committed_offset_next = committed_offset;
    timeout_count_next = timeout_count;
    res_count = 2'd0;
    r0 = '0;
    r1 = '0;
    pkt_end = long_packet ? LONG_END : SHORT_END;
    pkt_len = long_packet ? LONG_LEN : SHORT_LEN;
    pos = committed_offset + 21'(byte_index) - 21'd2;
    room = size_limit - committed_offset;
    rx_crc = {received_crc, rx_byte};
    if (req_type == REQ_START) begin
      committed_offset_next = '0;
      expected_block_next = 8'd1;
      timeout_count_next = '0;
      byte_index_next = '0;
      phase_next = PH_WAIT;
      r0.tx_valid = 1'b1;
      r0.tx_byte = CH_REQ;
      res_count = 2'd1;
    end else if (req_type == REQ_NONE || phase == PH_DONE) begin
      res_count = 2'd0;
    end else if (req_type == REQ_TIMEOUT) begin
      res_count = 2'd1;
      if (phase == PH_PACKET) begin
        phase_next = PH_WAIT;
        r0.tx_valid = 1'b1;
        r0.tx_byte = CH_NAK;
      end else if ({1'b0, timeout_count} + 5'd1 > {1'b0, retry_limit}) begin
        phase_next = PH_DONE;
        r0.done_res = 1'b1;
        r0.status = ST_TIMEOUT;
      end else begin
        timeout_count_next = timeout_count + 4'd1;
        r0.tx_valid = 1'b1;
        r0.tx_byte = CH_REQ;
      end
    end else if (phase == PH_WAIT) begin
      timeout_count_next = '0;
      if (rx_byte == CH_SOH || rx_byte == CH_STX) begin
        phase_next = PH_PACKET;
        long_packet_next = (rx_byte == CH_STX);
        byte_index_next = '0;
        running_crc_next = '0;
        received_crc_next = '0;
        header_ok_next = 1'b0;
      end else if (rx_byte == CH_EOT) begin
        phase_next = PH_DONE;
        r0.tx_valid = 1'b1;
        r0.tx_byte = CH_NAK;
        r1.tx_valid = 1'b1;
        r1.tx_byte = CH_ACK;
        r1.done_res = 1'b1;
        r1.status = ST_DONE;
        res_count = 2'd2;
      end else if (rx_byte == CH_CAN) begin
        phase_next = PH_DONE;
        r0.done_res = 1'b1;
        r0.status = ST_CANCEL;
        res_count = 2'd1;
      end
    end else begin
      byte_index_next = byte_index + 11'd1;
      if (byte_index == 11'd0) begin
        block_number_next = rx_byte;
      end else if (byte_index == 11'd1) begin
        header_ok_next = (8'(block_number + rx_byte) == 8'hFF);
      end else if (byte_index < pkt_end) begin
        running_crc_next = crc_byte(running_crc, rx_byte);
        if (header_ok && block_number == expected_block && pos < size_limit) begin
          r0.wr_valid = 1'b1;
          r0.wr_addr = base_addr + 32'(pos);
          r0.wr_data = rx_byte;
          res_count = 2'd1;
        end
      end else if (byte_index == pkt_end) begin
        received_crc_next = rx_byte;
      end else begin
        phase_next = PH_WAIT;
        res_count = 2'd1;
        r0.tx_valid = 1'b1;
        if (!header_ok || rx_crc != running_crc) begin
          r0.tx_byte = CH_NAK;
        end else begin
          r0.tx_byte = CH_ACK;
          if (block_number == expected_block) begin
            if (committed_offset < size_limit) begin
              committed_offset_next = committed_offset + ((room < pkt_len) ? room : pkt_len);
            end
            expected_block_next = expected_block + 8'd1;
          end
        end
      end
    end
    r0.saved_bytes = committed_offset_next;
    r1.saved_bytes = committed_offset_next;
    r0.last = (res_count == 2'd1);
    r1.last = 1'b1;
    res0 = r0;
    res1 = r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_addr <= 32'h2000_0000;
      size_limit <= 21'd4096;
      retry_limit <= 4'd10;
      phase <= PH_DONE;
      byte_index <= '0;
      long_packet <= 1'b0;
      block_number <= '0;
      header_ok <= 1'b0;
      running_crc <= '0;
      received_crc <= '0;
      expected_block <= 8'd1;
      committed_offset <= '0;
      timeout_count <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_BASE: base_addr <= cfg_data;
          CFG_SIZE: size_limit <= cfg_data[20:0];
          CFG_RETRY: retry_limit <= cfg_data[3:0];
          default: ;
        endcase
      end
      if (in_go) begin
        phase <= phase_next;
        byte_index <= byte_index_next;
        long_packet <= long_packet_next;
        block_number <= block_number_next;
        header_ok <= header_ok_next;
        running_crc <= running_crc_next;
        received_crc <= received_crc_next;
        expected_block <= expected_block_next;
        committed_offset <= committed_offset_next;
        timeout_count <= timeout_count_next;
      end
    end
  end

  `include "assert_macros.svh"
  `ASSERT_IMPL(a_two_only_eot, res_count == 2'd2, phase == PH_WAIT)
  `ASSERT_NEXT(a_start_waits, in_go && req_type == REQ_START, phase == PH_WAIT)
  `ASSERT_IMPL(a_offset_cap, committed_offset > size_limit, $stable(committed_offset))
endmodule

// File: src/ymcrc_queue.sv
// back part: four-result queue that drains one a beat while out_ready is high
// depends on ymcrc_pkg and assert_macros.svh
module ymcrc_queue
  import ymcrc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic [1:0] push_count,
  input  result_t    push0,
  input  result_t    push1,
  output logic       room2,
  output logic       out_valid,
  input  logic       out_ready,
  output result_t    out_data
);
  result_t     mem [4];
  logic [1:0]  rd_ptr, wr_ptr;
  logic [2:0]  count, count_next;
  logic        pop;

  assign pop = out_valid && out_ready;
  assign out_valid = (count != 3'd0);
  assign out_data = mem[rd_ptr];
  assign room2 = (count <= 3'd2);
  assign count_next = count + (push ? {1'b0, push_count} : 3'd0) - {2'b0, pop};

  always_ff @(posedge clk) begin
    if (push && push_count != 2'd0) mem[wr_ptr] <= push0;
    if (push && push_count == 2'd2) mem[wr_ptr + 2'd1] <= push1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count <= '0;
    end else begin
      if (pop) rd_ptr <= rd_ptr + 2'd1;
      if (push) wr_ptr <= wr_ptr + push_count;
      count <= count_next;
    end
  end

  `include "assert_macros.svh"
  `ASSERT_IMPL(a_no_overflow, push, count_next <= 3'd4)
  `ASSERT_IMPL(a_room_push, push && push_count != 2'd0, room2)
endmodule

// File: dv/tb.sv
// self-checking bench for the ymodem crc block receiver: drives event beats, predicts responses
// with an in-bench protocol model and compares every result beat field by field
// depends on ymcrc_pkg and ymodem_crc_block_receiver
module tb;
  import ymcrc_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int LONG_LEN = 1024;
  localparam int SHORT_LEN = 128;
  localparam int RANDOM_ITEMS = 100;

  typedef enum logic [1:0] {PH_IDLE, PH_HUNT, PH_BODY} rx_phase_t;
  typedef enum int {PKT_GOOD, PKT_BAD_HDR, PKT_BAD_CRC, PKT_CUT} pkt_kind_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;

  ymodem_crc_block_receiver i_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser), .m_axis_tlast(m_axis_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // model state and registers
  logic [31:0] m_base;
  logic [20:0] m_size_limit;
  logic [3:0]  m_retry_limit;
  rx_phase_t   m_phase;
  int unsigned m_index;
  logic        m_long;
  logic [7:0]  m_blk;
  logic        m_hdr_ok;
  logic [15:0] m_crc;
  logic [15:0] m_rx_crc;
  logic [7:0]  m_expected_blk;
  logic [20:0] m_offset;
  logic [3:0]  m_timeouts;

  result_t     resp_q[$];
  int          fail_count = 0;
  int          items_sent = 0;
  int          rx_hold = 0;
  int          idle_cycles = 0;
  logic        tx_burst = 1'b0;

  function automatic logic [15:0] xmodem_crc_step(logic [15:0] crc, logic [7:0] b);
    logic [15:0] r;
    r = crc ^ (16'(b) << 8);
    repeat (8) begin
      if (r[15]) r = (r << 1) ^ 16'h1021;
      else r = r << 1;
    end
    return r;
  endfunction

  function automatic void push_resp(logic txv, logic [7:0] txb, logic wrv, logic [31:0] addr,
                                    logic [7:0] data, logic done, logic [1:0] st);
    result_t r;
    r.tx_valid = txv;
    r.tx_byte = txb;
    r.wr_valid = wrv;
    r.wr_addr = addr;
    r.wr_data = data;
    r.done_res = done;
    r.status = st;
    r.saved_bytes = m_offset;
    r.last = 1'b0;
    resp_q.push_back(r);
  endfunction

  function automatic void model_event(logic [1:0] req, logic [7:0] b);
    int prior_count;
    int unsigned len;
    int unsigned pos;
    int unsigned room;
    result_t r;
    prior_count = resp_q.size();
    if (req == REQ_START) begin
      m_offset = '0;
      m_expected_blk = 8'd1;
      m_timeouts = '0;
      m_index = 0;
      m_phase = PH_HUNT;
      push_resp(1'b1, CH_REQ, 1'b0, '0, '0, 1'b0, ST_RUN);
    end else if (req == REQ_NONE || m_phase == PH_IDLE) begin
    end else if (req == REQ_TIMEOUT) begin
      if (m_phase == PH_BODY) begin
        m_phase = PH_HUNT;
        push_resp(1'b1, CH_NAK, 1'b0, '0, '0, 1'b0, ST_RUN);
      end else if (32'(m_timeouts) + 1 > 32'(m_retry_limit)) begin
        m_phase = PH_IDLE;
        push_resp(1'b0, '0, 1'b0, '0, '0, 1'b1, ST_TIMEOUT);
      end else begin
        m_timeouts = m_timeouts + 4'd1;
        push_resp(1'b1, CH_REQ, 1'b0, '0, '0, 1'b0, ST_RUN);
      end
    end else if (m_phase == PH_HUNT) begin
      m_timeouts = '0;
      if (b == CH_SOH || b == CH_STX) begin
        m_phase = PH_BODY;
        m_long = (b == CH_STX);
        m_index = 0;
        m_crc = '0;
        m_rx_crc = '0;
        m_hdr_ok = 1'b0;
      end else if (b == CH_EOT) begin
        m_phase = PH_IDLE;
        push_resp(1'b1, CH_NAK, 1'b0, '0, '0, 1'b0, ST_RUN);
        push_resp(1'b1, CH_ACK, 1'b0, '0, '0, 1'b1, ST_DONE);
      end else if (b == CH_CAN) begin
        m_phase = PH_IDLE;
        push_resp(1'b0, '0, 1'b0, '0, '0, 1'b1, ST_CANCEL);
      end
    end else begin
      len = m_long ? LONG_LEN : SHORT_LEN;
      if (m_index == 0) begin
        m_blk = b;
      end else if (m_index == 1) begin
        m_hdr_ok = (9'(m_blk) + 9'(b) == 9'h0FF);
      end else if (m_index < len + 2) begin
        pos = 32'(m_offset) + m_index - 2;
        m_crc = xmodem_crc_step(m_crc, b);
        if (m_hdr_ok && m_blk == m_expected_blk && pos < 32'(m_size_limit))
          push_resp(1'b0, '0, 1'b1, m_base + pos, b, 1'b0, ST_RUN);
      end else if (m_index == len + 2) begin
        m_rx_crc = {b, 8'h00};
      end else begin
        m_rx_crc[7:0] = b;
        m_phase = PH_HUNT;
        if (!m_hdr_ok || m_rx_crc != m_crc) begin
          push_resp(1'b1, CH_NAK, 1'b0, '0, '0, 1'b0, ST_RUN);
        end else begin
          if (m_blk == m_expected_blk) begin
            if (m_offset < m_size_limit) begin
              room = 32'(m_size_limit - m_offset);
              m_offset = m_offset + 21'((room < len) ? room : len);
            end
            m_expected_blk = m_expected_blk + 8'd1;
          end
          push_resp(1'b1, CH_ACK, 1'b0, '0, '0, 1'b0, ST_RUN);
        end
      end
      m_index = (m_index + 1) & 11'h7FF;
    end
    if (resp_q.size() > prior_count) begin
      r = resp_q[$];
      resp_q.pop_back();
      r.last = 1'b1;
      resp_q.push_back(r);
    end
  endfunction

  function automatic int draw_gap(logic burst);
    if (burst || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 4);
  endfunction

  task automatic send_event(logic [1:0] req, logic [7:0] b);
    int gap;
    gap = draw_gap(tx_burst);
    if (gap > 0) begin
      @(negedge clk) s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tuser <= req;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    model_event(req, b);
    items_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk) s_axis_tvalid <= 1'b0;
    while (resp_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    wait_idle();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk) cfg_we <= 1'b0;
    if (idx == CFG_BASE) m_base = val;
    else if (idx == CFG_SIZE) m_size_limit = val[20:0];
    else if (idx == CFG_RETRY) m_retry_limit = val[3:0];
  endtask

  task automatic send_block(logic is_long, logic [7:0] blk, pkt_kind_t kind);
    logic [15:0] crc;
    logic [7:0]  d;
    int unsigned len;
    int unsigned cut_at;
    len = is_long ? LONG_LEN : SHORT_LEN;
    cut_at = $urandom_range(0, is_long ? 16 : len + 2);
    crc = '0;
    send_event(REQ_BYTE, is_long ? CH_STX : CH_SOH);
    if (kind == PKT_CUT && cut_at == 0) begin
      send_event(REQ_TIMEOUT, '0);
      return;
    end
    send_event(REQ_BYTE, blk);
    send_event(REQ_BYTE, kind == PKT_BAD_HDR ? ~blk ^ 8'(1 << $urandom_range(0, 7)) : ~blk);
    for (int unsigned k = 0; k < len; k++) begin
      if (kind == PKT_CUT && k + 1 == cut_at) begin
        send_event(REQ_TIMEOUT, '0);
        return;
      end
      d = 8'($urandom);
      crc = xmodem_crc_step(crc, d);
      send_event(REQ_BYTE, d);
    end
    if (kind == PKT_BAD_CRC) crc = crc ^ 16'(1 << $urandom_range(0, 15));
    send_event(REQ_BYTE, crc[15:8]);
    send_event(REQ_BYTE, crc[7:0]);
  endtask

  // result side: per-beat stall, or a long hold when requested
  initial begin
    int stall;
    @(negedge clk);
    forever begin
      if (rx_hold > 0) begin
        stall = rx_hold;
        rx_hold = 0;
      end else begin
        stall = draw_gap(1'b0);
      end
      if (stall > 0) begin
        @(negedge clk) m_axis_tready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk) m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
    end
  end

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    result_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (resp_q.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual %h %h", $time,
                 m_axis_tuser, m_axis_tdata);
        fail_count++;
      end else begin
        e = resp_q.pop_front();
        check_field("tx_valid", 32'(e.tx_valid), 32'(m_axis_tuser[0]));
        check_field("tx_byte", 32'(e.tx_byte), 32'(m_axis_tdata[7:0]));
        check_field("wr_valid", 32'(e.wr_valid), 32'(m_axis_tuser[1]));
        check_field("wr_addr", e.wr_addr, m_axis_tdata[39:8]);
        check_field("wr_data", 32'(e.wr_data), 32'(m_axis_tdata[47:40]));
        check_field("done_res", 32'(e.done_res), 32'(m_axis_tuser[2]));
        check_field("status", 32'(e.status), 32'(m_axis_tdata[49:48]));
        check_field("saved_bytes", 32'(e.saved_bytes), 32'(m_axis_tdata[70:50]));
        check_field("last", 32'(e.last), 32'(m_axis_tlast));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic test_control();
    send_event(REQ_BYTE, CH_SOH);
    send_event(REQ_TIMEOUT, '0);
    send_event(REQ_NONE, 8'hFF);
    send_event(REQ_START, '0);
    send_event(REQ_NONE, 8'h00);
    send_event(REQ_BYTE, 8'hFF);
    send_event(REQ_BYTE, 8'h00);
    send_event(REQ_BYTE, CH_EOT);
    send_event(REQ_BYTE, 8'h55);
    send_event(REQ_START, 8'hAA);
    send_event(REQ_BYTE, CH_CAN);
    send_event(REQ_START, '0);
    send_event(REQ_START, '0);
  endtask

  task automatic test_timeouts();
    write_reg(CFG_RETRY, 32'd0);
    send_event(REQ_START, '0);
    send_event(REQ_TIMEOUT, '0);
    write_reg(CFG_RETRY, 32'd15);
    send_event(REQ_START, '0);
    repeat (5) send_event(REQ_TIMEOUT, '0);
    send_event(REQ_BYTE, 8'h7E);
    repeat (16) send_event(REQ_TIMEOUT, '0);
    write_reg(CFG_RETRY, 32'd3);
  endtask

  task automatic test_packets();
    write_reg(CFG_BASE, 32'hFFFF_FFC0);
    write_reg(CFG_SIZE, 32'd200);
    send_event(REQ_START, '0);
    send_block(1'b0, 8'd1, PKT_GOOD);
    send_block(1'b0, 8'd1, PKT_GOOD);
    send_block(1'b0, 8'd2, PKT_BAD_CRC);
    send_block(1'b0, 8'd2, PKT_CUT);
    send_block(1'b0, 8'd2, PKT_GOOD);
    send_event(REQ_BYTE, CH_EOT);
    write_reg(CFG_SIZE, 32'd1048576);
    write_reg(CFG_BASE, 32'h0000_0100);
    send_event(REQ_START, '0);
    send_block(1'b1, 8'd1, PKT_CUT);
    send_event(REQ_BYTE, CH_CAN);
  endtask

  task automatic test_pressure();
    write_reg(CFG_SIZE, 32'd4096);
    send_event(REQ_START, '0);
    rx_hold = 80;
    tx_burst = 1'b1;
    send_block(1'b0, 8'd1, PKT_GOOD);
    tx_burst = 1'b0;
    wait_idle();
  endtask

  task automatic test_random();
    int start_count;
    int pick;
    start_count = items_sent;
    while (items_sent - start_count < RANDOM_ITEMS) begin
      if ($urandom_range(0, 4) == 0) begin
        write_reg(CFG_BASE, $urandom);
        write_reg(CFG_SIZE, $urandom_range(0, 400));
        write_reg(CFG_RETRY, $urandom_range(0, 15));
        send_event(REQ_START, 8'($urandom));
      end
      tx_burst = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 19);
      if (pick < 12) begin
        send_block(1'b0, $urandom_range(0, 5) == 0 ? 8'($urandom) : m_expected_blk, PKT_GOOD);
      end else if (pick < 15) begin
        send_block(1'b0, m_expected_blk, pkt_kind_t'($urandom_range(1, 3)));
      end else if (pick < 17) begin
        repeat ($urandom_range(1, 5)) send_event(2'($urandom), 8'($urandom));
      end else if (pick == 17) begin
        send_event(REQ_BYTE, $urandom_range(0, 1) ? CH_EOT : CH_CAN);
        send_event(REQ_START, '0);
      end else begin
        repeat ($urandom_range(1, 4)) send_event(REQ_TIMEOUT, '0);
        if (m_phase == PH_IDLE) send_event(REQ_START, '0);
      end
    end
    tx_burst = 1'b0;
  endtask

  initial begin
    m_base = 32'h2000_0000;
    m_size_limit = 21'd4096;
    m_retry_limit = 4'd10;
    m_phase = PH_IDLE;
    m_index = 0;
    m_long = 1'b0;
    m_blk = '0;
    m_hdr_ok = 1'b0;
    m_crc = '0;
    m_rx_crc = '0;
    m_expected_blk = 8'd1;
    m_offset = '0;
    m_timeouts = '0;
    repeat (6) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    test_control();
    test_timeouts();
    test_packets();
    test_pressure();
    test_random();
    wait_idle();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && resp_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

// File: sim.f
+incdir+src
src/ymcrc_pkg.sv
src/ymcrc_engine.sv
src/ymcrc_queue.sv
src/ymodem_crc_block_receiver.sv
dv/tb.sv
